/* rtl/i2c_master_byte_engine_unit_assert.svh */
// ----------------------------------------------------------------------------
// i2c master byte engine assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define I2CMBE_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define I2CMBE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/i2cmbe_pkg.sv */
// ----------------------------------------------------------------------------
// i2c master byte engine package
// Widths, command codes, sequencer phase codes and reset constants.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmbe_pkg;

    localparam int OP_W    = 3;
    localparam int BYTE_W  = 8;
    localparam int HALF_W  = 10;
    localparam int PHASE_W = 4;
    localparam int BIT_W   = 3;

    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(30);
    localparam logic [BIT_W-1:0]  LAST_BIT   = BIT_W'(7);

    // commands
    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_START = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_ST1     = 4'd1;
    localparam logic [PHASE_W-1:0] PH_ST2     = 4'd2;
    localparam logic [PHASE_W-1:0] PH_SP1     = 4'd3;
    localparam logic [PHASE_W-1:0] PH_SP2     = 4'd4;
    localparam logic [PHASE_W-1:0] PH_WR_LOW  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_WR_HIGH = 4'd6;
    localparam logic [PHASE_W-1:0] PH_WA_LOW  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_WA_HIGH = 4'd8;
    localparam logic [PHASE_W-1:0] PH_RD_HIGH = 4'd9;
    localparam logic [PHASE_W-1:0] PH_RD_LOW  = 4'd10;
    localparam logic [PHASE_W-1:0] PH_RA_HIGH = 4'd11;

endpackage

`default_nettype wire

/* rtl/i2c_master_byte_engine_unit.sv */
// ----------------------------------------------------------------------------
// i2c master byte engine
// Tick-driven open-drain I2C master: start, stop, write byte, read byte.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction on the s_ channel is one bus tick carrying the
//   sampled SDA level and, while the engine is idle, an optional command.
//   Each tick yields exactly one m_ transaction with the SCL/SDA drive levels,
//   busy, done, the last write acknowledge and the last read byte.
//   The result of an accepted tick is registered and presented in the next cycle.
//   Throughput is one tick per cycle while s_ready is high; the sequencer
//   update is a single pass from the state registers into the result register.
//   A result held by a stalled receiver does not stop input as long as m_ready
//   frees the result register in the same cycle; otherwise s_ready drops until
//   the held result is taken.
//   cfg_wr_en/cfg_wr_data load the half-period tick count (0 acts as 1).
//   Reset: engine idle, SCL and SDA released, half period 30 ticks, no pending
//   result.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine_unit
    import i2cmbe_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,

    input  wire                 cfg_wr_en,
    input  wire  [HALF_W-1:0]   cfg_wr_data,

    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [OP_W-1:0]     s_op,
    input  wire  [BYTE_W-1:0]   s_write_byte,
    input  wire                 s_send_ack,
    input  wire                 s_sda_in,

    output logic                m_valid,
    input  wire                 m_ready,
    output logic                m_scl_out,
    output logic                m_sda_out,
    output logic                m_busy_res,
    output logic                m_done_res,
    output logic                m_ack_received,
    output logic [BYTE_W-1:0]   m_read_byte
);

    logic [HALF_W-1:0]  half_reg;
    logic [PHASE_W-1:0] phase_reg,  phase_next;
    logic [BIT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [HALF_W-1:0]  wait_cnt_reg, wait_cnt_next;
    logic [BYTE_W-1:0]  shift_reg,  shift_next;
    logic               scl_reg,    scl_next;
    logic               sda_reg,    sda_next;
    logic               ack_reg,    ack_next;
    logic               ack_tx_reg, ack_tx_next;
    logic [BYTE_W-1:0]  rd_hold_reg, rd_hold_next;
    logic               done_next;

    logic               m_valid_reg;
    logic               m_scl_reg, m_sda_reg, m_busy_reg, m_done_reg, m_ack_reg;
    logic [BYTE_W-1:0]  m_rd_reg;

    logic               accept;
    logic [HALF_W-1:0]  delay_load;

    assign s_ready    = !m_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;
    assign delay_load = (half_reg == '0) ? HALF_W'(1) : half_reg;

    // one sequencer step per tick
    always_comb begin
        phase_next    = phase_reg;
        bit_cnt_next  = bit_cnt_reg;
        wait_cnt_next = wait_cnt_reg;
        shift_next    = shift_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        ack_next      = ack_reg;
        ack_tx_next   = ack_tx_reg;
        rd_hold_next  = rd_hold_reg;
        done_next     = 1'b0;

        if (phase_reg == PH_IDLE) begin
            unique case (s_op)
                OP_START: begin
                    sda_next      = 1'b1;
                    scl_next      = 1'b1;
                    wait_cnt_next = delay_load;
                    phase_next    = PH_ST1;
                end
                OP_STOP: begin
                    sda_next      = 1'b0;
                    scl_next      = 1'b1;
                    wait_cnt_next = delay_load;
                    phase_next    = PH_SP1;
                end
                OP_WRITE: begin
                    shift_next    = s_write_byte;
                    bit_cnt_next  = '0;
                    sda_next      = s_write_byte[BYTE_W-1];
                    wait_cnt_next = delay_load;
                    phase_next    = PH_WR_LOW;
                end
                OP_READ: begin
                    ack_tx_next   = s_send_ack;
                    shift_next    = '0;
                    bit_cnt_next  = '0;
                    sda_next      = 1'b1;
                    scl_next      = 1'b1;
                    wait_cnt_next = delay_load;
                    phase_next    = PH_RD_HIGH;
                end
                default: begin
                end
            endcase
        end else if (wait_cnt_reg > HALF_W'(1)) begin
            wait_cnt_next = wait_cnt_reg - HALF_W'(1);
        end else begin
            wait_cnt_next = '0;
            unique case (phase_reg)
                PH_ST1: begin
                    sda_next      = 1'b0;
                    wait_cnt_next = delay_load;
                    phase_next    = PH_ST2;
                end
                PH_ST2: begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                PH_SP1: begin
                    sda_next      = 1'b1;
                    wait_cnt_next = delay_load;
                    phase_next    = PH_SP2;
                end
                PH_SP2: begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                PH_WR_LOW: begin
                    scl_next      = 1'b1;
                    wait_cnt_next = delay_load;
                    phase_next    = PH_WR_HIGH;
                end
                PH_WR_HIGH: begin
                    scl_next      = 1'b0;
                    shift_next    = {shift_reg[BYTE_W-2:0], 1'b0};
                    wait_cnt_next = delay_load;
                    if (bit_cnt_reg == LAST_BIT) begin
                        // release sda for the slave acknowledge
                        sda_next   = 1'b1;
                        phase_next = PH_WA_LOW;
                    end else begin
                        bit_cnt_next = bit_cnt_reg + BIT_W'(1);
                        sda_next     = shift_reg[BYTE_W-2];
                        phase_next   = PH_WR_LOW;
                    end
                end
                PH_WA_LOW: begin
                    scl_next      = 1'b1;
                    wait_cnt_next = delay_load;
                    phase_next    = PH_WA_HIGH;
                end
                PH_WA_HIGH: begin
                    ack_next   = !s_sda_in;
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                PH_RD_HIGH: begin
                    shift_next    = {shift_reg[BYTE_W-2:0], s_sda_in};
                    scl_next      = 1'b0;
                    wait_cnt_next = delay_load;
                    phase_next    = PH_RD_LOW;
                end
                PH_RD_LOW: begin
                    scl_next      = 1'b1;
                    wait_cnt_next = delay_load;
                    if (bit_cnt_reg == LAST_BIT) begin
                        sda_next   = !ack_tx_reg;
                        phase_next = PH_RA_HIGH;
                    end else begin
                        bit_cnt_next = bit_cnt_reg + BIT_W'(1);
                        phase_next   = PH_RD_HIGH;
                    end
                end
                PH_RA_HIGH: begin
                    scl_next     = 1'b0;
                    sda_next     = 1'b1;
                    rd_hold_next = shift_reg;
                    phase_next   = PH_IDLE;
                    done_next    = 1'b1;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg <= HALF_RESET;
        end else if (cfg_wr_en) begin
            half_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            bit_cnt_reg  <= '0;
            wait_cnt_reg <= '0;
            shift_reg    <= '0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            ack_reg      <= 1'b0;
            ack_tx_reg   <= 1'b0;
            rd_hold_reg  <= '0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            bit_cnt_reg  <= bit_cnt_next;
            wait_cnt_reg <= wait_cnt_next;
            shift_reg    <= shift_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            ack_reg      <= ack_next;
            ack_tx_reg   <= ack_tx_next;
            rd_hold_reg  <= rd_hold_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_scl_reg  <= scl_next;
            m_sda_reg  <= sda_next;
            m_busy_reg <= (phase_next != PH_IDLE);
            m_done_reg <= done_next;
            m_ack_reg  <= ack_next;
            m_rd_reg   <= rd_hold_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_scl_out      = m_scl_reg;
    assign m_sda_out      = m_sda_reg;
    assign m_busy_res     = m_busy_reg;
    assign m_done_res     = m_done_reg;
    assign m_ack_received = m_ack_reg;
    assign m_read_byte    = m_rd_reg;

    `include "i2c_master_byte_engine_unit_assert.svh"

    `I2CMBE_ASSERT_NOW(a_wait_nonzero, phase_reg != PH_IDLE, wait_cnt_reg != '0, "active phase with empty delay counter")
    `I2CMBE_ASSERT_NOW(a_done_not_busy, m_valid_reg && m_done_reg, !m_busy_reg, "done reported while still busy")
    `I2CMBE_ASSERT_NEXT(a_busy_tracks_phase, accept, m_busy_reg == (phase_reg != PH_IDLE), "busy flag disagrees with phase")
    `I2CMBE_ASSERT_NEXT(a_idle_no_cmd, accept && phase_reg == PH_IDLE && s_op != OP_START && s_op != OP_STOP && s_op != OP_WRITE && s_op != OP_READ, phase_reg == PH_IDLE, "idle engine left idle without a command")

endmodule

`default_nettype wire
